@@ design/lru_handle_slot_table_defines.svh @@
// Assertion macros used by the checker file of the slot table.
`ifndef LRU_HANDLE_SLOT_TABLE_DEFINES_SVH
`define LRU_HANDLE_SLOT_TABLE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LHST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table assertion failed");

// Antecedent implies consequent in the next cycle.
`define LHST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table assertion failed");

`endif

@@ design/lhst_pkg.sv @@
// Package with the types and constants of the LRU handle slot table.
package lhst_pkg;

   // Default number of slots in the table.
   localparam int SLOTS_DEF = 10;

   // Field widths.
   localparam int OWNER_W = 8;
   localparam int STAMP_W = 32;
   localparam int SLOT_W  = 4;

   // Request action codes.
   localparam logic ACT_ACCESS  = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // One request word.
   typedef struct packed {
      logic               action;
      logic [OWNER_W-1:0] owner;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               hit;
      logic               evicted;
      logic [OWNER_W-1:0] evicted_owner;
      logic               released;
      logic               stamp_overflow;
   } rsp_type;

   // Control of the scan unit from the sequencer.
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

endpackage

@@ design/lhst_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module lhst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lhst_scan.sv @@
// Scan unit: looks at one table entry per cycle while sample is set, for an owner match and the oldest stamp.
module lhst_scan #(
   parameter int SLOTS = lhst_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  lhst_pkg::scan_ctl_type        ctl,
   input  logic [$clog2(SLOTS)-1:0]      idx,
   input  logic                          entry_valid,
   input  logic [lhst_pkg::OWNER_W-1:0]  entry_owner,
   input  logic [lhst_pkg::STAMP_W-1:0]  entry_stamp,
   input  logic [lhst_pkg::OWNER_W-1:0]  owner,
   output logic                          found,
   output logic [$clog2(SLOTS)-1:0]      found_idx,
   output logic [$clog2(SLOTS)-1:0]      min_idx,
   output logic [lhst_pkg::OWNER_W-1:0]  min_owner
);

   localparam int IDX_W = $clog2(SLOTS);

   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]              min_idx_ff, min_idx_in;
   logic [lhst_pkg::OWNER_W-1:0]  min_owner_ff, min_owner_in;
   logic [lhst_pkg::STAMP_W-1:0]  min_stamp_ff, min_stamp_in;

   // Keep the first matching slot and the oldest stamp; a tie keeps the lower index.
   always_comb begin
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      min_idx_in   = min_idx_ff;
      min_owner_in = min_owner_ff;
      min_stamp_in = min_stamp_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample) begin
         if (!found_ff && entry_valid && (entry_owner == owner)) begin
            found_in     = 1'b1;
            found_idx_in = idx;
         end
         if ((idx == '0) || (entry_stamp < min_stamp_ff)) begin
            min_idx_in   = idx;
            min_owner_in = entry_owner;
            min_stamp_in = entry_stamp;
         end
      end
   end

   // The clear at each new request resets the search, so no reset is needed here.
   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      min_idx_ff   <= min_idx_in;
      min_owner_ff <= min_owner_in;
      min_stamp_ff <= min_stamp_in;
   end

   assign found     = found_ff;
   assign found_idx = found_idx_ff;
   assign min_idx   = min_idx_ff;
   assign min_owner = min_owner_ff;

endmodule

@@ design/lru_handle_slot_table.sv @@
// Top level of the LRU handle slot table: sequencer, valid bits, use counter and output register.
//
// Each request word is accepted in the idle state and then passes through a scan state, in
// which the owner and stamp memory is read slot by slot through its single read port, a
// drain state in which the last read lands, and an update state for the table update and
// write-back. One request is worked on at a time; the next one is taken while the previous
// response still waits in the output register. An access that misses and finds no free
// slot evicts the slot with the oldest stamp, the lower index winning a tie. The
// stamp_overflow flag is sticky once the 32-bit use counter wraps, after which eviction
// order may be wrong. Slot numbers are reported in four bits.
module lru_handle_slot_table #(
   parameter int SLOTS = lhst_pkg::SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lhst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lhst_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int ENT_W = lhst_pkg::OWNER_W + lhst_pkg::STAMP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   lhst_pkg::req_type            req_ff, req_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         sample_ff;
   logic [IDX_W-1:0]             samp_idx_ff;
   logic [SLOTS-1:0]             valid_ff, valid_in;
   logic [lhst_pkg::STAMP_W-1:0] counter_ff, counter_in;
   logic                         wrap_ff, wrap_in;
   lhst_pkg::rsp_type            res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lhst_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic                         out_free;
   lhst_pkg::scan_ctl_type       scan_ctl;
   logic                         found;
   logic [IDX_W-1:0]             found_idx;
   logic [IDX_W-1:0]             min_idx;
   logic [lhst_pkg::OWNER_W-1:0] min_owner;
   logic [IDX_W-1:0]             free_idx;
   logic                         all_valid;
   logic [IDX_W-1:0]             tgt_idx;
   logic                         ram_we;
   logic [ENT_W-1:0]             ram_rdata;

   // Handshake.
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Owner and stamp of every slot live in one memory.
   lhst_ram #(
      .WIDTH(ENT_W),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(tgt_idx),
      .wr_data({req_ff.owner, counter_ff}),
      .rd_addr(addr_ff),
      .rd_data(ram_rdata)
   );

   // Scan control: clear on a new word, sample each read that lands.
   assign scan_ctl.clear  = accept;
   assign scan_ctl.sample = sample_ff;

   lhst_scan #(
      .SLOTS(SLOTS)
   ) u_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .idx        (samp_idx_ff),
      .entry_valid(valid_ff[samp_idx_ff]),
      .entry_owner(ram_rdata[ENT_W-1:lhst_pkg::STAMP_W]),
      .entry_stamp(ram_rdata[lhst_pkg::STAMP_W-1:0]),
      .owner      (req_ff.owner),
      .found      (found),
      .found_idx  (found_idx),
      .min_idx    (min_idx),
      .min_owner  (min_owner)
   );

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign all_valid = &valid_ff;

   // Sequencer, table update and result.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      valid_in     = valid_ff;
      counter_in   = counter_ff;
      wrap_in      = wrap_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      tgt_idx      = found_idx;
      ram_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            res_in = '0;
            if (req_ff.action == lhst_pkg::ACT_RELEASE) begin
               // A release clears the slot if the owner is present.
               if (found) begin
                  valid_in[found_idx] = 1'b0;
                  res_in.slot         = lhst_pkg::SLOT_W'(found_idx);
                  res_in.hit          = 1'b1;
                  res_in.released     = 1'b1;
               end
            end else begin
               // An access restamps a hit, else fills a free slot, else evicts the oldest.
               if (found) begin
                  tgt_idx    = found_idx;
                  res_in.hit = 1'b1;
               end else if (!all_valid) begin
                  tgt_idx = free_idx;
               end else begin
                  tgt_idx              = min_idx;
                  res_in.evicted       = 1'b1;
                  res_in.evicted_owner = min_owner;
               end
               ram_we            = 1'b1;
               valid_in[tgt_idx] = 1'b1;
               counter_in        = counter_ff + 1'b1;
               if (counter_ff == '1) begin
                  wrap_in = 1'b1;
               end
               res_in.slot = lhst_pkg::SLOT_W'(tgt_idx);
            end
            res_in.stamp_overflow = wrap_in;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_in;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sample_ff    <= 1'b0;
         valid_ff     <= '0;
         counter_ff   <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sample_ff    <= (state_ff == ST_SCAN);
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      addr_ff     <= addr_in;
      samp_idx_ff <= addr_ff;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/lhst_checker.sv @@
// Port checker for the LRU handle slot table and its bind to the top level.
`include "lru_handle_slot_table_defines.svh"

module lhst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lhst_pkg::rsp_type rsp_data
);

   logic       req_acc;
   logic       rsp_acc;
   logic       flags_ok;
   logic [2:0] pending_ff, pending_in;
   logic       wrap_seen_ff, wrap_seen_in;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // An eviction is never a hit or a release, and a release is always a hit.
   assign flags_ok = !(rsp_data.evicted && (rsp_data.hit || rsp_data.released)) &&
                     (!rsp_data.released || rsp_data.hit);

   // Words accepted but not yet answered, and whether a wrap was reported.
   always_comb begin
      pending_in   = pending_ff + {2'b00, req_acc} - {2'b00, rsp_acc};
      wrap_seen_in = wrap_seen_ff || (rsp_acc && rsp_data.stamp_overflow);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         wrap_seen_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         wrap_seen_ff <= wrap_seen_in;
      end
   end

   // Every response word answers an earlier request word.
   `LHST_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_acc, pending_ff != 3'd0)

   // At most one word in work and one waiting at the output.
   `LHST_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff <= 3'd2)

   // The wrap flag never falls once reported.
   `LHST_ASSERT_NOW(a_wrap_sticky, clock, reset, rsp_acc && wrap_seen_ff, rsp_data.stamp_overflow)

   // The result flags of a response word are consistent.
   `LHST_ASSERT_NOW(a_flags_legal, clock, reset, rsp_valid, flags_ok)

   // A stalled response word holds.
   `LHST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind lru_handle_slot_table lhst_checker u_lhst_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the LRU handle slot table, checked against a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SLOTS     = lhst_pkg::SLOTS_DEF;
   localparam int LATENCY     = N_SLOTS + 3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 12;
   localparam int NOISE_PCT   = 15;
   localparam int RELEASE_PCT = 20;
   localparam int HOLD_AT     = 60;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_FROM  = 320;
   localparam int QUIET_TO    = 400;
   localparam int PRINT_MAX   = 40;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lhst_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lhst_pkg::rsp_type rsp_data;

   // Words waiting to be offered, and responses the table should give back.
   lhst_pkg::req_type pending_words[$];
   lhst_pkg::rsp_type expected_rsp[$];

   int   n_pushed    = 0;
   int   n_taken     = 0;
   int   n_checked   = 0;
   int   n_errors    = 0;
   int   cycle_count = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic req_taken   = 1'b0;
   logic quiet;

   // Shadow copy of the slot table.
   logic                         shadow_valid [N_SLOTS] = '{default: 1'b0};
   logic [lhst_pkg::OWNER_W-1:0] shadow_owner [N_SLOTS];
   logic [lhst_pkg::STAMP_W-1:0] shadow_stamp [N_SLOTS];
   logic [lhst_pkg::STAMP_W-1:0] use_count = '0;
   logic                         wrapped   = 1'b0;

   lru_handle_slot_table #(.SLOTS(N_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // A stretch of the run in which neither side idles.
   assign quiet = (n_taken >= QUIET_FROM) && (n_taken < QUIET_TO);

   // Applies one request word to the shadow table and returns the response it should cause.
   function automatic lhst_pkg::rsp_type apply_request(lhst_pkg::req_type w);
      lhst_pkg::rsp_type r;
      int                found;
      int                target;
      r     = '0;
      found = -1;
      for (int i = N_SLOTS - 1; i >= 0; i--)
         if (shadow_valid[i] && shadow_owner[i] == w.owner) found = i;
      if (w.action == lhst_pkg::ACT_RELEASE) begin
         // Releasing an owner that is not present changes nothing.
         if (found >= 0) begin
            shadow_valid[found] = 1'b0;
            r.slot     = lhst_pkg::SLOT_W'(found);
            r.hit      = 1'b1;
            r.released = 1'b1;
         end
      end else begin
         if (found >= 0) begin
            target = found;
            r.hit  = 1'b1;
         end else begin
            target = -1;
            for (int i = N_SLOTS - 1; i >= 0; i--)
               if (!shadow_valid[i]) target = i;
            if (target < 0) begin
               // Table full: the oldest stamp goes, the lower index winning a tie.
               target = 0;
               for (int i = 1; i < N_SLOTS; i++)
                  if (shadow_stamp[i] < shadow_stamp[target]) target = i;
               r.evicted       = 1'b1;
               r.evicted_owner = shadow_owner[target];
            end
            shadow_valid[target] = 1'b1;
            shadow_owner[target] = w.owner;
         end
         // Every access, hit or miss, takes the next counter value.
         shadow_stamp[target] = use_count;
         use_count = use_count + 1'b1;
         if (use_count == '0) wrapped = 1'b1;
         r.slot = lhst_pkg::SLOT_W'(target);
      end
      r.stamp_overflow = wrapped;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      if (n_errors < PRINT_MAX) $display("mismatch: %s", what);
      n_errors++;
   endtask

   task automatic add_word(logic act, logic [lhst_pkg::OWNER_W-1:0] own);
      lhst_pkg::req_type w;
      w.action = act;
      w.owner  = own;
      pending_words.push_back(w);
      n_pushed++;
   endtask

   // Mostly accesses and releases from a small set of owners, so that hits, frees and
   // evictions all occur; the rest is random noise over the whole owner range.
   task automatic add_random(int count, int pool_size);
      logic [lhst_pkg::OWNER_W-1:0] pool [$];
      logic                         act;
      logic [lhst_pkg::OWNER_W-1:0] own;
      repeat (pool_size) pool.push_back(lhst_pkg::OWNER_W'($urandom_range(255)));
      repeat (count) begin
         if ($urandom_range(99) < NOISE_PCT) begin
            act = 1'($urandom_range(1));
            own = lhst_pkg::OWNER_W'($urandom_range(255));
         end else begin
            act = ($urandom_range(99) < RELEASE_PCT) ? lhst_pkg::ACT_RELEASE
                                                      : lhst_pkg::ACT_ACCESS;
            own = pool[$urandom_range(pool_size - 1)];
         end
         add_word(act, own);
      end
   endtask

   // Holds the sender back until every response so far has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (n_taken != n_pushed || expected_rsp.size() != 0);
      @(posedge clock);
   endtask

   // Sender: a new word goes out only once the previous one was taken.
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (!reset && pending_words.size() != 0 &&
             (quiet || $urandom_range(99) >= IDLE_PCT)) begin
            req_data  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that lets the table back up.
   always @(negedge clock) begin
      if (!hold_done && n_taken >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      lhst_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_request(req_data));
            n_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.slot !== want.slot)
                  report_mismatch($sformatf("word %0d slot got %0d want %0d",
                                            n_checked, rsp_data.slot, want.slot));
               if (rsp_data.hit !== want.hit)
                  report_mismatch($sformatf("word %0d hit got %0b want %0b",
                                            n_checked, rsp_data.hit, want.hit));
               if (rsp_data.evicted !== want.evicted)
                  report_mismatch($sformatf("word %0d evicted got %0b want %0b",
                                            n_checked, rsp_data.evicted, want.evicted));
               if (rsp_data.evicted_owner !== want.evicted_owner)
                  report_mismatch($sformatf("word %0d evicted_owner got %0h want %0h",
                                            n_checked, rsp_data.evicted_owner,
                                            want.evicted_owner));
               if (rsp_data.released !== want.released)
                  report_mismatch($sformatf("word %0d released got %0b want %0b",
                                            n_checked, rsp_data.released, want.released));
               if (rsp_data.stamp_overflow !== want.stamp_overflow)
                  report_mismatch($sformatf("word %0d stamp_overflow got %0b want %0b",
                                            n_checked, rsp_data.stamp_overflow,
                                            want.stamp_overflow));
               n_checked++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Release on an empty table, extreme owners, a hit and a release hit.
      add_word(lhst_pkg::ACT_RELEASE, 8'h00);
      add_word(lhst_pkg::ACT_ACCESS,  8'h00);
      add_word(lhst_pkg::ACT_ACCESS,  8'hFF);
      add_word(lhst_pkg::ACT_ACCESS,  8'h00);
      add_word(lhst_pkg::ACT_RELEASE, 8'hFF);
      add_word(lhst_pkg::ACT_RELEASE, 8'hFF);
      // Fill every slot, the freed one first.
      add_word(lhst_pkg::ACT_ACCESS,  8'hAA);
      add_word(lhst_pkg::ACT_ACCESS,  8'h55);
      add_word(lhst_pkg::ACT_ACCESS,  8'h01);
      add_word(lhst_pkg::ACT_ACCESS,  8'h02);
      add_word(lhst_pkg::ACT_ACCESS,  8'h04);
      add_word(lhst_pkg::ACT_ACCESS,  8'h08);
      add_word(lhst_pkg::ACT_ACCESS,  8'h10);
      add_word(lhst_pkg::ACT_ACCESS,  8'h20);
      add_word(lhst_pkg::ACT_ACCESS,  8'h40);
      // Full table: new owners evict, a release opens a slot again.
      add_word(lhst_pkg::ACT_ACCESS,  8'h80);
      add_word(lhst_pkg::ACT_ACCESS,  8'h00);
      add_word(lhst_pkg::ACT_ACCESS,  8'h55);
      add_word(lhst_pkg::ACT_RELEASE, 8'h04);
      add_word(lhst_pkg::ACT_ACCESS,  8'hFF);
      add_word(lhst_pkg::ACT_ACCESS,  8'h7F);
      add_word(lhst_pkg::ACT_RELEASE, 8'h00);
      wait_drained();

      add_random(150, 14);
      wait_drained();
      add_random(130, 6);
      add_random(150, 16);
      wait_drained();

      // Let any stray response show up before deciding.
      repeat (3 * LATENCY) @(posedge clock);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/lhst_pkg.sv
design/lhst_ram.sv
design/lhst_scan.sv
design/lru_handle_slot_table.sv
design/lhst_checker.sv
tb/testbench.sv
